// ----- src/awm_pkg.sv -----
// shared types and constants for the anagram window matcher
package awm_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 6;
    localparam int NZ_W        = 9;
    localparam int TABLE_DEPTH = 256;
    localparam int START_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_LEN_W   = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_REMOVE,
        ST_ADD,
        ST_WAIT,
        ST_DONE
    } t_state;

    // one read-modify-write request to the count table
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] addr;
        logic              inc;
    } t_adj_req;

endpackage

// ----- src/awm_text_if.sv -----
// handshake channel carrying text beats
interface awm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       restart;

    modport source (output valid, output text_byte, output restart, input ready);
    modport sink   (input valid, input text_byte, input restart, output ready);
endinterface

// ----- src/awm_result_if.sv -----
// handshake channel carrying result beats
interface awm_result_if;
    logic        valid;
    logic        ready;
    logic        match;
    logic [15:0] match_start;

    modport source (output valid, output match, output match_start, input ready);
    modport sink   (input valid, input match, input match_start, output ready);
endinterface

// ----- src/awm_count_table.sv -----
// per-byte-value count difference memory with nonzero entry tracking
module awm_count_table
    import awm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  t_adj_req        i_req,
    output logic [NZ_W-1:0] o_nonzero
);

    logic signed [CNT_W-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_vld;
    logic [NZ_W-1:0]         r_nonzero;

    logic                    r_s2_valid;
    logic [BYTE_W-1:0]       r_s2_addr;
    logic                    r_s2_inc;
    logic                    r_s2_vbit;
    logic                    r_s2_fwd;
    logic signed [CNT_W-1:0] r_fwd_data;
    logic signed [CNT_W-1:0] r_rd_data;

    logic signed [CNT_W-1:0] w_before;
    logic signed [CNT_W-1:0] w_after;

    // memory read at request time, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_rd_data <= mem[i_req.addr];
        end
        if (r_s2_valid) begin
            mem[r_s2_addr] <= w_after;
        end
    end

    // second-stage payload, forward when the pending write hits the new address
    always_ff @(posedge i_clk) begin
        r_s2_addr  <= i_req.addr;
        r_s2_inc   <= i_req.inc;
        r_s2_vbit  <= r_vld[i_req.addr];
        r_s2_fwd   <= r_s2_valid && (r_s2_addr == i_req.addr);
        r_fwd_data <= w_after;
    end

    // modify: entries never written since clear read as zero
    always_comb begin
        if (r_s2_fwd) begin
            w_before = r_fwd_data;
        end else if (r_s2_vbit) begin
            w_before = r_rd_data;
        end else begin
            w_before = '0;
        end
        w_after = r_s2_inc ? (w_before + CNT_W'(1)) : (w_before - CNT_W'(1));
    end

    // valid bits and nonzero count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_vld      <= '0;
            r_nonzero  <= '0;
        end else begin
            r_s2_valid <= i_req.valid;
            if (i_clear) begin
                r_vld     <= '0;
                r_nonzero <= '0;
            end else if (r_s2_valid) begin
                r_vld[r_s2_addr] <= 1'b1;
                if ((w_before == '0) && (w_after != '0)) begin
                    r_nonzero <= r_nonzero + NZ_W'(1);
                end else if ((w_before != '0) && (w_after == '0)) begin
                    r_nonzero <= r_nonzero - NZ_W'(1);
                end
            end
        end
    end

    assign o_nonzero = r_nonzero;

    // checks
    a_nz_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonzero <= NZ_W'(TABLE_DEPTH))
        else $error("nonzero count exceeds table depth");

    a_nz_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_clear |=> (r_nonzero == $past(r_nonzero)) ||
                     (r_nonzero == $past(r_nonzero) + NZ_W'(1)) ||
                     (r_nonzero == $past(r_nonzero) - NZ_W'(1)))
        else $error("nonzero count moved by more than one");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear && !i_req.valid |=> (r_nonzero == '0) && (r_vld == '0))
        else $error("clear did not empty the table");

endmodule

// ----- src/anagram_window_matcher.sv -----
// anagram window matcher top level: sequencer, window ring and result register
// each text beat runs through the remove, add, wait and done states; a restart beat first loads the pattern
// into the table, and before the first restart a beat goes straight to done; a new beat is taken only in idle
// the step order is set by the read-modify-write steps on the count table (one read, one write port)
// reset: synchronous, clears control state and all table valid bits
// a restart empties the table the same way, with no clearing sweep
module anagram_window_matcher
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int INDEX_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    awm_text_if.sink              i_text,
    awm_result_if.source          o_result
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [CFG_LEN_W-1:0]  r_cfg_len;

    // control state
    t_state                r_state;
    t_state                n_state;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_fill;
    logic [PTR_W-1:0]      r_ptr;
    logic [PTR_W-1:0]      r_k;
    logic [INDEX_BITS-1:0] r_pos;
    logic                  r_out_valid;

    // payload state
    logic [BYTE_W-1:0]     r_byte;
    logic [BYTE_W-1:0]     r_win  [MAX_PATTERN];
    logic [BYTE_W-1:0]     r_lpat [MAX_PATTERN];
    logic                  r_out_match;
    logic [START_W-1:0]    r_out_start;

    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_out_load;
    logic                  w_clear;
    t_adj_req              w_req;
    logic [NZ_W-1:0]       w_nonzero;
    logic [LEN_W-1:0]      w_len_clamp;
    logic [LEN_W-1:0]      w_ptr_inc;
    logic [LEN_W-1:0]      w_k_inc;
    logic                  w_full;
    logic                  w_match;
    logic [INDEX_BITS-1:0] w_start;
    logic [2*CFG_DATA_W-1:0] w_pat_all;

    assign w_accept  = i_text.valid && w_in_ready;
    assign w_pat_all = {r_pat_hi, r_pat_lo};
    assign w_ptr_inc = LEN_W'(r_ptr) + LEN_W'(1);
    assign w_k_inc   = LEN_W'(r_k) + LEN_W'(1);
    assign w_full    = (r_fill >= r_len);
    assign w_match   = (r_len != '0) && w_full && (w_nonzero == '0);
    assign w_start   = r_pos - INDEX_BITS'(r_len) + INDEX_BITS'(1);

    // length clamp at latch time
    always_comb begin
        if (r_cfg_len == '0) begin
            w_len_clamp = LEN_W'(1);
        end else if (r_cfg_len > CFG_LEN_W'(MAX_PATTERN)) begin
            w_len_clamp = LEN_W'(MAX_PATTERN);
        end else begin
            w_len_clamp = LEN_W'(r_cfg_len);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_cfg_len <= CFG_LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_cfg_len <= i_cfg_data[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state and table requests
    always_comb begin
        n_state    = r_state;
        w_req      = '0;
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_clear    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_text.valid) begin
                    if (i_text.restart) begin
                        w_clear = 1'b1;
                        n_state = ST_LOAD;
                    end else if (r_len == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_REMOVE;
                    end
                end
            end
            ST_LOAD: begin
                w_req.valid = 1'b1;
                w_req.addr  = r_lpat[r_k];
                w_req.inc   = 1'b0;
                if (w_k_inc >= r_len) begin
                    n_state = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                w_req.valid = w_full;
                w_req.addr  = r_win[r_ptr];
                w_req.inc   = 1'b0;
                n_state     = ST_ADD;
            end
            ST_ADD: begin
                w_req.valid = 1'b1;
                w_req.addr  = r_byte;
                w_req.inc   = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_k         <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_text.restart) begin
                r_len  <= w_len_clamp;
                r_fill <= '0;
                r_ptr  <= '0;
                r_k    <= '0;
                r_pos  <= '0;
            end
            if (r_state == ST_LOAD) begin
                r_k <= r_k + PTR_W'(1);
            end
            if (r_state == ST_ADD) begin
                r_ptr <= (w_ptr_inc >= r_len) ? '0 : PTR_W'(w_ptr_inc);
                if (!w_full) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
            end
            if (w_out_load) begin
                r_pos       <= r_pos + INDEX_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: input beat, window ring, latched pattern, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_text.text_byte;
            if (i_text.restart) begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    r_lpat[i] <= w_pat_all[i*BYTE_W +: BYTE_W];
                end
            end
        end
        if (r_state == ST_ADD) begin
            r_win[r_ptr] <= r_byte;
        end
        if (w_out_load) begin
            r_out_match <= w_match;
            r_out_start <= w_match ? START_W'(w_start) : '0;
        end
    end

    awm_count_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_req     (w_req),
        .o_nonzero (w_nonzero)
    );

    assign i_text.ready         = w_in_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.match       = r_out_match;
    assign o_result.match_start = r_out_start;

    // checks
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PATTERN))
        else $error("latched length above maximum");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("window fill beyond window length");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> (LEN_W'(r_ptr) < r_len))
        else $error("ring pointer outside window");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.match |-> (o_result.match_start == '0))
        else $error("start index set without a match");

endmodule
